FILE: hw/rtl/sls_pkg.sv
// Shared types and constants for the sorted line store editor.
package sls_pkg;

    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 13;
    localparam int USED_W    = 13;
    localparam int LINE_W    = 15;
    localparam int RADDR_W   = 12;
    localparam int BYTE_W    = 8;

    localparam int HDR_BYTES  = 3;
    localparam int TERM_BYTES = 2;

    typedef enum logic [KIND_W-1:0] {
        K_STAGE  = 2'd0,
        K_COMMIT = 2'd1,
        K_CLEAR  = 2'd2,
        K_READ   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        S_OK       = 2'd0,
        S_NOROOM   = 2'd1,
        S_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDW,
        ST_LOC0,
        ST_LOC1,
        ST_LOC2,
        ST_LOC3,
        ST_DCOPY,
        ST_CHECK,
        ST_ICOPY,
        ST_HDR0,
        ST_HDR1,
        ST_HDR2,
        ST_TCOPY
    } state_t;

endpackage

FILE: hw/rtl/sls_mem.sv
// Simple dual-port RAM: one write port, one registered read port.
module sls_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/sorted_line_store_editor.sv
// Sorted line store editor: program lines kept in a byte store in line order.
// One item in, one result out. A store read waits in ST_RDW for the registered
// RAM output. A commit to a nonzero line walks the records through ST_LOC0 to
// ST_LOC3 for each record passed, shifts the store tail one byte per cycle to
// close the gap of a replaced record and, for non-empty text with room, again
// to open the new one, then writes the three header bytes and copies the staged
// text at one byte per cycle; the single write port of the store RAM sets these
// rates. No item is taken while a commit is in progress.
module sorted_line_store_editor
    import sls_pkg::*;
#(
    parameter int STORE_BYTES = 4096,
    parameter int TEXT_MAX    = 255
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [KIND_W-1:0]   kind,
    input  logic [BYTE_W-1:0]   text_byte,
    input  logic [LINE_W-1:0]   line_number,
    input  logic [RADDR_W-1:0]  read_address,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic                replaced,
    output logic [USED_W-1:0]   used_size,
    output logic [BYTE_W-1:0]   read_byte,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam int UW = AW + 1;
    localparam int TW = $clog2(TEXT_MAX);
    localparam int LW = $clog2(TEXT_MAX + 1);
    localparam int SW = ((UW > CFG_W) ? UW : CFG_W) + 1;

    state_t              state_reg, state_next;
    logic [UW-1:0]       used_reg, used_next;
    logic [UW-1:0]       pos_reg, pos_next;
    logic [LW-1:0]       slen_reg, slen_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [LINE_W-1:0]   target_reg, target_next;
    logic [BYTE_W-1:0]   lo_reg, lo_next;
    logic [BYTE_W-1:0]   hi_reg, hi_next;
    logic                repl_reg, repl_next;
    logic                rd_hit_reg, rd_hit_next;
    logic [CFG_W-1:0]    max_size_reg;
    logic [UW-1:0]       src_reg, src_next;
    logic [UW-1:0]       dst_reg, dst_next;
    logic [UW-1:0]       cnt_reg, cnt_next;
    logic                wv_reg, wv_next;
    logic [AW-1:0]       wa_reg, wa_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                replaced_reg, replaced_next;
    logic [UW-1:0]       used_out_reg, used_out_next;
    logic [BYTE_W-1:0]   rd_out_reg, rd_out_next;

    logic                st_we;
    logic [AW-1:0]       st_wa, st_ra;
    logic [BYTE_W-1:0]   st_wd, st_rd;
    logic                tx_we;
    logic [TW-1:0]       tx_wa, tx_ra;
    logic [BYTE_W-1:0]   tx_rd;

    logic                in_acc;
    logic                fin;
    status_t             fin_status;
    logic [BYTE_W-1:0]   fin_rd;
    logic [UW-1:0]       rec;
    logic [UW-1:0]       gap;
    logic [SW-1:0]       need;
    logic [SW-1:0]       limit;
    logic                copy_run;
    logic                copy_down;

    sls_mem #(.DEPTH(STORE_BYTES), .WIDTH(BYTE_W)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_wa),
        .wdata (st_wd),
        .raddr (st_ra),
        .rdata (st_rd)
    );

    sls_mem #(.DEPTH(TEXT_MAX), .WIDTH(BYTE_W)) u_text (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_wa),
        .wdata (text_byte),
        .raddr (tx_ra),
        .rdata (tx_rd)
    );

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign replaced  = replaced_reg;
    assign used_size = USED_W'(used_out_reg);
    assign read_byte = rd_out_reg;

    assign rec   = UW'(st_rd) + UW'(HDR_BYTES);
    assign gap   = UW'(len_reg) + UW'(HDR_BYTES);
    assign need  = SW'(used_reg) + SW'(len_reg) + SW'(HDR_BYTES);
    assign limit = (SW'(max_size_reg) < SW'(STORE_BYTES)) ? SW'(max_size_reg)
                                                         : SW'(STORE_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg <= CFG_W'(4096);
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_size_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= UW'(TERM_BYTES);
            slen_reg      <= '0;
            wv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            slen_reg      <= slen_next;
            wv_reg        <= wv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        len_reg      <= len_next;
        target_reg   <= target_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        repl_reg     <= repl_next;
        rd_hit_reg   <= rd_hit_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        cnt_reg      <= cnt_next;
        wa_reg       <= wa_next;
        status_reg   <= status_next;
        replaced_reg <= replaced_next;
        used_out_reg <= used_out_next;
        rd_out_reg   <= rd_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        pos_next       = pos_reg;
        slen_next      = slen_reg;
        len_next       = len_reg;
        target_next    = target_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        repl_next      = repl_reg;
        rd_hit_next    = rd_hit_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        cnt_next       = cnt_reg;
        wv_next        = 1'b0;
        wa_next        = wa_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        replaced_next  = replaced_reg;
        used_out_next  = used_out_reg;
        rd_out_next    = rd_out_reg;

        st_we      = 1'b0;
        st_wa      = wa_reg;
        st_wd      = (state_reg == ST_TCOPY) ? tx_rd : st_rd;
        st_ra      = src_reg[AW-1:0];
        tx_we      = 1'b0;
        tx_wa      = slen_reg[TW-1:0];
        tx_ra      = src_reg[TW-1:0];
        fin        = 1'b0;
        fin_status = S_OK;
        fin_rd     = '0;
        copy_run   = 1'b0;
        copy_down  = 1'b0;

        // retire the byte read in the previous cycle of a copy
        if (wv_reg)
        begin
            st_we = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    repl_next = 1'b0;
                    unique case (kind_t'(kind))
                        K_STAGE:
                        begin
                            if (slen_reg < LW'(TEXT_MAX))
                            begin
                                tx_we     = 1'b1;
                                slen_next = slen_reg + 1'b1;
                            end
                            else
                            begin
                                fin_status = S_OVERFLOW;
                            end
                            fin = 1'b1;
                        end
                        K_COMMIT:
                        begin
                            slen_next = '0;
                            if (line_number == '0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                len_next    = slen_reg;
                                target_next = line_number;
                                pos_next    = '0;
                                state_next  = ST_LOC0;
                            end
                        end
                        K_CLEAR:
                        begin
                            used_next = UW'(TERM_BYTES);
                            slen_next = '0;
                            fin       = 1'b1;
                        end
                        K_READ:
                        begin
                            // the terminator is never stored; it reads as zero
                            st_ra       = AW'(read_address);
                            rd_hit_next = SW'(read_address) + SW'(TERM_BYTES) < SW'(used_reg);
                            state_next  = ST_RDW;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_RDW:
            begin
                fin_rd     = rd_hit_reg ? st_rd : '0;
                fin        = 1'b1;
                state_next = ST_IDLE;
            end
            ST_LOC0:
            begin
                if (pos_reg + UW'(TERM_BYTES) >= used_reg)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    st_ra      = pos_reg[AW-1:0];
                    state_next = ST_LOC1;
                end
            end
            ST_LOC1:
            begin
                st_ra      = AW'(pos_reg + 1'b1);
                lo_next    = st_rd;
                state_next = ST_LOC2;
            end
            ST_LOC2:
            begin
                st_ra      = AW'(pos_reg + UW'(2));
                hi_next    = st_rd;
                state_next = ST_LOC3;
            end
            ST_LOC3:
            begin
                if ({hi_reg, lo_reg} < {1'b0, target_reg})
                begin
                    pos_next   = pos_reg + rec;
                    state_next = ST_LOC0;
                end
                else if ({hi_reg, lo_reg} == {1'b0, target_reg})
                begin
                    // close the gap left by the old record
                    repl_next  = 1'b1;
                    src_next   = pos_reg + rec;
                    dst_next   = pos_reg;
                    cnt_next   = used_reg - UW'(TERM_BYTES) - pos_reg - rec;
                    used_next  = used_reg - rec;
                    state_next = ST_DCOPY;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_DCOPY:
            begin
                copy_run = 1'b1;
                if (cnt_reg == '0 && !wv_reg)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (need >= limit)
                begin
                    fin_status = S_NOROOM;
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (len_reg == '0)
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // open a gap, moving the tail from its top byte down
                    src_next   = used_reg - UW'(TERM_BYTES + 1);
                    dst_next   = used_reg - UW'(TERM_BYTES + 1) + gap;
                    cnt_next   = used_reg - UW'(TERM_BYTES) - pos_reg;
                    used_next  = used_reg + gap;
                    state_next = ST_ICOPY;
                end
            end
            ST_ICOPY:
            begin
                copy_run  = 1'b1;
                copy_down = 1'b1;
                if (cnt_reg == '0 && !wv_reg)
                begin
                    state_next = ST_HDR0;
                end
            end
            ST_HDR0:
            begin
                st_we      = 1'b1;
                st_wa      = pos_reg[AW-1:0];
                st_wd      = target_reg[7:0];
                state_next = ST_HDR1;
            end
            ST_HDR1:
            begin
                st_we      = 1'b1;
                st_wa      = AW'(pos_reg + 1'b1);
                st_wd      = {1'b0, target_reg[LINE_W-1:8]};
                state_next = ST_HDR2;
            end
            ST_HDR2:
            begin
                st_we      = 1'b1;
                st_wa      = AW'(pos_reg + UW'(2));
                st_wd      = BYTE_W'(len_reg);
                src_next   = '0;
                dst_next   = pos_reg + UW'(HDR_BYTES);
                cnt_next   = UW'(len_reg);
                state_next = ST_TCOPY;
            end
            ST_TCOPY:
            begin
                copy_run = 1'b1;
                if (cnt_reg == '0 && !wv_reg)
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // issue one read per cycle; the write follows in the next cycle
        if (copy_run && cnt_reg != '0)
        begin
            wv_next  = 1'b1;
            wa_next  = dst_reg[AW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (copy_down)
            begin
                src_next = src_reg - 1'b1;
                dst_next = dst_reg - 1'b1;
            end
            else
            begin
                src_next = src_reg + 1'b1;
                dst_next = dst_reg + 1'b1;
            end
        end

        if (fin)
        begin
            out_valid_next = 1'b1;
            status_next    = fin_status;
            replaced_next  = repl_next;
            used_out_next  = used_next;
            rd_out_next    = fin_rd;
        end
    end

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("item accepted while a commit is in progress");

    a_write_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
        wv_reg |-> (state_reg == ST_DCOPY || state_reg == ST_ICOPY
                    || state_reg == ST_TCOPY))
        else $error("copy write outside a copy phase");

    a_used_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg >= UW'(TERM_BYTES) && used_reg <= UW'(STORE_BYTES))
        else $error("used size out of range");

    a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slen_reg <= LW'(TEXT_MAX))
        else $error("staged length beyond capacity");

    a_commit_empties: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && kind == K_COMMIT |=> slen_reg == '0)
        else $error("commit left text staged");

endmodule
